@@ hdl/gimli_pkg.sv @@
package gimli_pkg;

  localparam int ROUND_COUNT = 24;
  localparam int WORD_BITS = 32;
  localparam int COLS = 4;
  localparam int WORDS = 12;
  localparam logic [WORD_BITS-1:0] RC_BASE = 32'h9e377900;

  typedef logic [WORD_BITS-1:0] word_t;
  // word index = row * COLS + col
  typedef word_t [WORDS-1:0] state_t;

endpackage

@@ hdl/gimli_spbox.sv @@
module gimli_spbox (
  input  gimli_pkg::word_t row0_in,
  input  gimli_pkg::word_t row1_in,
  input  gimli_pkg::word_t row2_in,
  output gimli_pkg::word_t row0_out,
  output gimli_pkg::word_t row1_out,
  output gimli_pkg::word_t row2_out
);

  gimli_pkg::word_t x;
  gimli_pkg::word_t y;
  gimli_pkg::word_t z;

  assign x = {row0_in[7:0], row0_in[31:8]};
  assign y = {row1_in[22:0], row1_in[31:23]};
  assign z = row2_in;

  assign row2_out = x ^ (z << 1) ^ ((y & z) << 2);
  assign row1_out = y ^ x ^ ((x | z) << 1);
  assign row0_out = z ^ y ^ ((x & y) << 3);

endmodule

@@ hdl/gimli_round.sv @@
module gimli_round #(
  parameter int ROUND = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gimli_pkg::state_t   in_state,
  output logic                out_valid,
  input  logic                out_ready,
  output gimli_pkg::state_t   out_state
);

  localparam gimli_pkg::word_t RC = gimli_pkg::RC_BASE ^ gimli_pkg::word_t'(ROUND);

  gimli_pkg::state_t sp;
  gimli_pkg::state_t mixed;

  for (genvar col = 0; col < gimli_pkg::COLS; col++) begin : g_lane
    gimli_spbox u_lane (
      .row0_in  (in_state[col]),
      .row1_in  (in_state[gimli_pkg::COLS + col]),
      .row2_in  (in_state[2*gimli_pkg::COLS + col]),
      .row0_out (sp[col]),
      .row1_out (sp[gimli_pkg::COLS + col]),
      .row2_out (sp[2*gimli_pkg::COLS + col])
    );
  end

  // row 0 shuffle: small swap plus constant, or big swap, or none in the other rounds
  always_comb begin
    mixed = sp;
    unique case (ROUND % 4)
      0: begin
        mixed[0] = sp[1] ^ RC;
        mixed[1] = sp[0];
        mixed[2] = sp[3];
        mixed[3] = sp[2];
      end
      2: begin
        mixed[0] = sp[2];
        mixed[1] = sp[3];
        mixed[2] = sp[0];
        mixed[3] = sp[1];
      end
      default: begin
        mixed = sp;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_state <= mixed;
    end
  end

endmodule

@@ hdl/gimli_permutation_top.sv @@
// Gimli-384 permutation, one round per pipeline stage, four column lanes per stage.
// One register per round, ROUND 24 at the input down to ROUND 1 at the output.
// Throughput: one state per cycle unless the output blocks; ready ripples through every
// stage in the same cycle, so a blocked output holds the run of full stages behind it
// and bubbles are filled.
// Reset: synchronous active-high rst clears all stage valid flags; data is not reset.
module gimli_permutation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_r0_c0,
  input  logic [31:0] in_r0_c1,
  input  logic [31:0] in_r0_c2,
  input  logic [31:0] in_r0_c3,
  input  logic [31:0] in_r1_c0,
  input  logic [31:0] in_r1_c1,
  input  logic [31:0] in_r1_c2,
  input  logic [31:0] in_r1_c3,
  input  logic [31:0] in_r2_c0,
  input  logic [31:0] in_r2_c1,
  input  logic [31:0] in_r2_c2,
  input  logic [31:0] in_r2_c3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_r0_c0,
  output logic [31:0] out_r0_c1,
  output logic [31:0] out_r0_c2,
  output logic [31:0] out_r0_c3,
  output logic [31:0] out_r1_c0,
  output logic [31:0] out_r1_c1,
  output logic [31:0] out_r1_c2,
  output logic [31:0] out_r1_c3,
  output logic [31:0] out_r2_c0,
  output logic [31:0] out_r2_c1,
  output logic [31:0] out_r2_c2,
  output logic [31:0] out_r2_c3
);

  localparam int N = gimli_pkg::ROUND_COUNT;

  logic              stage_valid [N+1];
  logic              stage_ready [N+1];
  gimli_pkg::state_t stage_state [N+1];

  assign stage_valid[0] = in_valid;
  assign in_ready       = stage_ready[0];
  assign stage_state[0] = {in_r2_c3, in_r2_c2, in_r2_c1, in_r2_c0,
                           in_r1_c3, in_r1_c2, in_r1_c1, in_r1_c0,
                           in_r0_c3, in_r0_c2, in_r0_c1, in_r0_c0};

  for (genvar i = 0; i < N; i++) begin : g_round
    gimli_round #(.ROUND(N - i)) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_state  (stage_state[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_state (stage_state[i+1])
    );
  end

  assign out_valid      = stage_valid[N];
  assign stage_ready[N] = out_ready;

  assign out_r0_c0 = stage_state[N][0];
  assign out_r0_c1 = stage_state[N][1];
  assign out_r0_c2 = stage_state[N][2];
  assign out_r0_c3 = stage_state[N][3];
  assign out_r1_c0 = stage_state[N][4];
  assign out_r1_c1 = stage_state[N][5];
  assign out_r1_c2 = stage_state[N][6];
  assign out_r1_c3 = stage_state[N][7];
  assign out_r2_c0 = stage_state[N][8];
  assign out_r2_c1 = stage_state[N][9];
  assign out_r2_c2 = stage_state[N][10];
  assign out_r2_c3 = stage_state[N][11];

endmodule

@@ hdl/gimli_checker.sv @@
module gimli_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_r0_c0,
  input logic [31:0] out_r1_c1,
  input logic [31:0] out_r2_c3
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // an unblocked output means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output side not blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before accept");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(out_r0_c0) && $stable(out_r1_c1) && $stable(out_r2_c3))
    else $error("output word changed while stalled");

endmodule

bind gimli_permutation_top gimli_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_r0_c0 (out_r0_c0),
  .out_r1_c1 (out_r1_c1),
  .out_r2_c3 (out_r2_c3)
);
